FILE: src/float32_dot_product_unit_macros.svh
// assertion macros for the binary32 dot product checker
`ifndef FLOAT32_DOT_PRODUCT_UNIT_MACROS_SVH
`define FLOAT32_DOT_PRODUCT_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define FDP_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked during reset too
`define FDP_ASSERT_NEXT(label, clk, cond, prop, msg) \
   label: assert property (@(posedge clk) (cond) |=> (prop)) else $error(msg);

`endif

FILE: src/fdp_pkg.sv
// types, constants and binary32 arithmetic functions of the dot product unit
package fdp_pkg;

   localparam logic [31:0] QNAN_BITS = 32'h7FC00000;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   function automatic logic [4:0] lzc27(logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic [5:0] lzc48(logic [47:0] v);
      logic [5:0] n;
      logic       found;
      n = 6'd48;
      found = 1'b0;
      for (int i = 47; i >= 0; i--) begin
         if (!found && v[i]) begin
            n = 6'(47 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // binary32 add, round to nearest even, nan made canonical
   function automatic logic [31:0] fp_add(logic [31:0] x, logic [31:0] y);
      logic        xn, yn, xi, yi;
      logic [31:0] big, sml;
      logic [7:0]  eb, es, d;
      logic [23:0] mb, ms;
      logic [26:0] ab, as_, sh;
      logic        sticky;
      logic [27:0] s;
      logic [26:0] n;
      logic [4:0]  lz;
      logic [8:0]  e, shamt;
      logic [7:0]  ef;
      logic        up;
      logic [31:0] r;
      xn = (&x[30:23]) && (|x[22:0]);
      yn = (&y[30:23]) && (|y[22:0]);
      xi = (&x[30:23]) && !(|x[22:0]);
      yi = (&y[30:23]) && !(|y[22:0]);
      r = 32'd0;
      if (xn || yn || (xi && yi && (x[31] != y[31]))) begin
         r = QNAN_BITS;
      end else if (xi) begin
         r = x;
      end else if (yi) begin
         r = y;
      end else begin
         if (x[30:0] >= y[30:0]) begin
            big = x;
            sml = y;
         end else begin
            big = y;
            sml = x;
         end
         eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
         es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
         mb = {|big[30:23], big[22:0]};
         ms = {|sml[30:23], sml[22:0]};
         d = eb - es;
         ab = {mb, 3'b000};
         as_ = {ms, 3'b000};
         if (d >= 8'd27) begin
            sh = {26'd0, |ms};
         end else begin
            sticky = |(as_ & ((27'd1 << d) - 27'd1));
            sh = (as_ >> d) | {26'd0, sticky};
         end
         if (big[31] == sml[31]) begin
            s = {1'b0, ab} + {1'b0, sh};
         end else begin
            s = {1'b0, ab} - {1'b0, sh};
         end
         if (s == 28'd0) begin
            r = {big[31] & sml[31], 31'd0};
         end else begin
            if (s[27]) begin
               n = s[27:1] | {26'd0, s[0]};
               e = {1'b0, eb} + 9'd1;
            end else begin
               lz = lzc27(s[26:0]);
               shamt = ({4'd0, lz} < ({1'b0, eb} - 9'd1)) ? {4'd0, lz} : ({1'b0, eb} - 9'd1);
               n = s[26:0] << shamt;
               e = {1'b0, eb} - shamt;
            end
            if (e >= 9'd255) begin
               r = {big[31], 8'hFF, 23'd0};
            end else begin
               ef = n[26] ? e[7:0] : 8'd0;
               up = n[2] & (n[1] | n[0] | n[3]);
               r = {big[31], ef, n[25:3]} + {31'd0, up};
            end
         end
      end
      return r;
   endfunction

   // normalize and round a raw significand product
   function automatic logic [31:0] fp_mul_round(logic sgn, logic [8:0] eab, logic [47:0] p,
                                                logic nan, logic inf);
      logic [5:0]         lz;
      logic [47:0]        q, qs;
      logic signed [10:0] e;
      logic [10:0]        rs;
      logic               sticky, up;
      logic [7:0]         ef;
      logic [31:0]        r;
      r = 32'd0;
      if (nan) begin
         r = QNAN_BITS;
      end else if (inf) begin
         r = {sgn, 8'hFF, 23'd0};
      end else if (p == 48'd0) begin
         r = {sgn, 31'd0};
      end else begin
         lz = lzc48(p);
         q = p << lz;
         e = $signed({2'b00, eab}) - 11'sd126 - $signed({5'd0, lz});
         if (e > 11'sd254) begin
            r = {sgn, 8'hFF, 23'd0};
         end else begin
            if (e < 11'sd1) begin
               rs = 11'(11'sd1 - e);
               if (rs >= 11'd48) begin
                  qs = {47'd0, |q};
               end else begin
                  sticky = |(q & ((48'd1 << rs) - 48'd1));
                  qs = (q >> rs) | {47'd0, sticky};
               end
               ef = 8'd0;
            end else begin
               qs = q;
               ef = e[7:0];
            end
            up = qs[23] & ((|qs[22:0]) | qs[24]);
            r = {sgn, ef, qs[46:24]} + {31'd0, up};
         end
      end
      return r;
   endfunction

endpackage

FILE: src/fdp_mul.sv
// binary32 multiplier: significand product stage, then normalize and round stage
module fdp_mul
   import fdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_in,
   input  logic [31:0] a_bits,
   input  logic [31:0] b_bits,
   output ctl_type     ctl_out,
   output logic [31:0] prod_bits
);

   logic        an, bn, ai, bi, az, bz;
   ctl_type     ctl1_ff, ctl2_ff;
   logic        sgn_ff, nan_ff, inf_ff;
   logic [8:0]  eab_ff;
   logic [47:0] p_ff;
   logic [31:0] prod_ff;
   logic [7:0]  ea, eb;

   always_comb begin
      an = (&a_bits[30:23]) && (|a_bits[22:0]);
      bn = (&b_bits[30:23]) && (|b_bits[22:0]);
      ai = (&a_bits[30:23]) && !(|a_bits[22:0]);
      bi = (&b_bits[30:23]) && !(|b_bits[22:0]);
      az = (a_bits[30:0] == 31'd0);
      bz = (b_bits[30:0] == 31'd0);
      ea = (a_bits[30:23] == 8'd0) ? 8'd1 : a_bits[30:23];
      eb = (b_bits[30:23] == 8'd0) ? 8'd1 : b_bits[30:23];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sgn_ff <= a_bits[31] ^ b_bits[31];
         nan_ff <= an || bn || (ai && bz) || (bi && az);
         inf_ff <= ai || bi;
         eab_ff <= {1'b0, ea} + {1'b0, eb};
         p_ff <= {|a_bits[30:23], a_bits[22:0]} * {|b_bits[30:23], b_bits[22:0]};
         prod_ff <= fp_mul_round(sgn_ff, eab_ff, p_ff, nan_ff, inf_ff);
      end
   end

   assign ctl_out = ctl2_ff;
   assign prod_bits = prod_ff;

endmodule

FILE: src/fdp_acc.sv
// accumulators with parity steering and the final pair of sums
module fdp_acc
   import fdp_pkg::*;
#(
   parameter int ACCUMULATORS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  ctl_type     ctl_in,
   input  logic [31:0] prod_bits,
   output logic        fin_valid,
   output logic [31:0] fin_x,
   output logic [31:0] fin_y
);

   logic [31:0] sum_even_ff, sum_odd_ff, sum_even_in, sum_odd_in;
   logic        parity_ff, parity_in, to_odd;
   logic        fin_valid_ff;
   logic [31:0] fin_x_ff, fin_y_ff, acc_sum;

   always_comb begin
      to_odd = (ACCUMULATORS >= 2) && parity_ff;
      acc_sum = fp_add(to_odd ? sum_odd_ff : sum_even_ff, prod_bits);
      sum_even_in = to_odd ? sum_even_ff : acc_sum;
      sum_odd_in = to_odd ? acc_sum : sum_odd_ff;
      parity_in = (ACCUMULATORS >= 2) ? !parity_ff : 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_even_ff <= 32'd0;
         sum_odd_ff <= 32'd0;
         parity_ff <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_valid_ff <= ctl_in.valid && ctl_in.last;
         if (ctl_in.valid) begin
            if (ctl_in.last) begin
               sum_even_ff <= 32'd0;
               sum_odd_ff <= 32'd0;
               parity_ff <= 1'b0;
            end else begin
               sum_even_ff <= sum_even_in;
               sum_odd_ff <= sum_odd_in;
               parity_ff <= parity_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_x_ff <= sum_even_in;
         fin_y_ff <= sum_odd_in;
      end
   end

   assign fin_valid = fin_valid_ff;
   assign fin_x = fin_x_ff;
   assign fin_y = fin_y_ff;

endmodule

FILE: src/float32_dot_product_unit.sv
// Streaming binary32 dot product. One pair is taken per clock while the result side
// is not stalled; the result of a vector then passes through the product, rounding,
// accumulate and final add registers, which follow the input register that the taking
// edge loads. The rate of one pair per cycle is set by the accumulate adder, whose
// loop back into its sum register is combinational.
// Multiply and add round separately to nearest even, subnormals are kept, and a nan
// result is always 0x7FC00000. The whole pipeline holds while a result waits stalled.
module float32_dot_product_unit
   import fdp_pkg::*;
#(
   parameter int ACCUMULATORS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a_bits,
   input  logic [31:0] req_b_bits,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_bits
);

   logic        advance;
   ctl_type     in_ctl_ff, mul_ctl;
   logic [31:0] a_ff, b_ff, prod_bits, fin_x, fin_y;
   logic        fin_valid;
   logic        rsp_valid_ff;
   logic [31:0] rsp_result_ff;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ctl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_ctl_ff <= '{valid: req_valid, last: req_last_element};
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff <= req_a_bits;
         b_ff <= req_b_bits;
         rsp_result_ff <= fp_add(fin_x, fin_y);
      end
   end

   fdp_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (in_ctl_ff),
      .a_bits    (a_ff),
      .b_bits    (b_ff),
      .ctl_out   (mul_ctl),
      .prod_bits (prod_bits)
   );

   fdp_acc #(
      .ACCUMULATORS (ACCUMULATORS)
   ) u_acc (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .ctl_in    (mul_ctl),
      .prod_bits (prod_bits),
      .fin_valid (fin_valid),
      .fin_x     (fin_x),
      .fin_y     (fin_y)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_bits = rsp_result_ff;

endmodule

FILE: src/fdp_checker.sv
// port-level checks for the dot product unit, bound to the top level
`include "float32_dot_product_unit_macros.svh"

module fdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_bits
);

   // the input only stalls behind a waiting result
   `FDP_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with no waiting result")
   // a held result keeps its value
   `FDP_ASSERT_NOW(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall) && !$past(reset), rsp_valid && $stable(rsp_result_bits), "stalled result changed")
   // no result right after reset
   `FDP_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid && !req_stall, "result or stall right after reset")

endmodule

bind float32_dot_product_unit fdp_checker u_fdp_checker (.*);

FILE: tb/float32_dot_product_unit_tb.sv
// testbench of the streaming binary32 dot product unit
`timescale 1ns / 1ps

module float32_dot_product_unit_tb;
   import fdp_pkg::*;

   typedef struct {
      logic [31:0] a;
      logic [31:0] b;
      logic        last;
      bit          known;
      logic [31:0] want;
   } pair_row_type;

   localparam int RANDOM_ITEMS = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_a_bits = 32'd0;
   logic [31:0] req_b_bits = 32'd0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_result_bits;

   logic [31:0] expected_dot_products[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;

   // predictor state
   logic [31:0] sum_even_acc = 32'd0;
   logic [31:0] sum_odd_acc = 32'd0;
   logic        odd_turn = 1'b0;

   float32_dot_product_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_a_bits(req_a_bits),
      .req_b_bits(req_b_bits),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_bits(rsp_result_bits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_nan(logic [31:0] x);
      return (&x[30:23]) && (|x[22:0]);
   endfunction

   function automatic bit is_inf(logic [31:0] x);
      return (&x[30:23]) && !(|x[22:0]);
   endfunction

   function automatic real float_bits_to_real(logic [31:0] x);
      real v;
      if (x[30:23] == 8'd0) begin
         v = real'(x[22:0]) * (2.0 ** (-149));
      end else begin
         v = $bitstoreal({1'b0, 11'({3'd0, x[30:23]} + 11'd896), x[22:0], 29'd0});
      end
      if (x[31]) begin
         v = -v;
      end
      return v;
   endfunction

   // round an exact (or innocuously double-rounded) value to binary32, nearest even
   function automatic logic [31:0] real_to_float_bits(real r);
      logic [63:0] d, sig, q;
      int          e, sh;
      logic        g, st, up;
      logic [30:0] mag;
      d = $realtobits(r);
      if (d[62:52] == 11'd0) begin
         return {d[63], 31'd0};
      end
      e = int'(d[62:52]) - 1023;
      if (e > 127) begin
         return {d[63], 8'hFF, 23'd0};
      end
      sig = {11'd0, 1'b1, d[51:0]};
      sh = (e >= -126) ? 29 : 29 + (-126 - e);
      if (sh > 60) begin
         q = 64'd0;
         g = 1'b0;
         st = 1'b1;
      end else begin
         q = sig >> sh;
         g = sig[sh-1];
         st = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
      end
      up = g & (st | q[0]);
      if (e >= -126) begin
         mag = {8'(e + 127), q[22:0]} + 31'(up);
      end else begin
         mag = {8'd0, q[22:0]} + 31'(up);
      end
      return {d[63], mag};
   endfunction

   function automatic logic [31:0] float_mul(logic [31:0] x, logic [31:0] y);
      logic s;
      s = x[31] ^ y[31];
      if (is_nan(x) || is_nan(y)) begin
         return QNAN_BITS;
      end
      if (is_inf(x) || is_inf(y)) begin
         if (x[30:0] == 31'd0 || y[30:0] == 31'd0) begin
            return QNAN_BITS;
         end
         return {s, 8'hFF, 23'd0};
      end
      return real_to_float_bits(float_bits_to_real(x) * float_bits_to_real(y));
   endfunction

   function automatic logic [31:0] float_add(logic [31:0] x, logic [31:0] y);
      if (is_nan(x) || is_nan(y)) begin
         return QNAN_BITS;
      end
      if (is_inf(x) && is_inf(y)) begin
         return (x[31] == y[31]) ? x : QNAN_BITS;
      end
      if (is_inf(x)) begin
         return x;
      end
      if (is_inf(y)) begin
         return y;
      end
      return real_to_float_bits(float_bits_to_real(x) + float_bits_to_real(y));
   endfunction

   // accumulate one pair; returns 1 and the dot product on the last pair
   function automatic bit dot_step(logic [31:0] a, logic [31:0] b, logic last,
                                   output logic [31:0] dot);
      logic [31:0] prod;
      prod = float_mul(a, b);
      dot = 32'd0;
      if (odd_turn) begin
         sum_odd_acc = float_add(sum_odd_acc, prod);
      end else begin
         sum_even_acc = float_add(sum_even_acc, prod);
      end
      odd_turn = ~odd_turn;
      if (!last) begin
         return 1'b0;
      end
      dot = float_add(sum_even_acc, sum_odd_acc);
      if (is_nan(dot)) begin
         dot = QNAN_BITS;
      end
      sum_even_acc = 32'd0;
      sum_odd_acc = 32'd0;
      odd_turn = 1'b0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last, bit known,
                            logic [31:0] want);
      logic [31:0] dot;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_a_bits <= a;
      req_b_bits <= b;
      req_last_element <= last;
      do
         @(posedge clock);
      while (req_stall);
      if (dot_step(a, b, last, dot)) begin
         expected_dot_products.push_back(known ? want : dot);
      end
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      logic [31:0] specials[10] = '{32'h00000000, 32'h80000000, 32'h7F800000,
                                    32'hFF800000, 32'h7FC00000, 32'h7F800001,
                                    32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF,
                                    32'h00800000};
      case ($urandom_range(9))
         0, 1: return $urandom;
         2: return specials[$urandom_range(9)];
         3: return {1'($urandom), 8'd0, 23'($urandom)};
         default: return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
      endcase
   endfunction

   // receiver stalls, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dot_products.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_bits, 32'hx);
         end else begin
            logic [31:0] want;
            want = expected_dot_products.pop_front();
            if (rsp_result_bits !== want) begin
               report_mismatch("result_bits", rsp_result_bits, want);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      pair_row_type rows[$];
      int           remaining;
      int           len;
      rows = '{
         '{32'h3F800000, 32'h3F800000, 1'b1, 1'b1, 32'h3F800000},
         '{32'h7FC00001, 32'h3F800000, 1'b1, 1'b1, 32'h7FC00000},  // nan payload
         '{32'h7F800000, 32'h00000000, 1'b1, 1'b1, 32'h7FC00000},  // inf times zero
         '{32'h00000000, 32'h80000000, 1'b1, 1'b1, 32'h00000000},  // signed zero
         '{32'h7F800000, 32'h3F800000, 1'b1, 1'b1, 32'h7F800000},
         '{32'hFF800000, 32'h3F800000, 1'b1, 1'b1, 32'hFF800000},
         '{32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, 1'b1, 32'h7F800000},  // overflow
         '{32'h00000001, 32'h3F000000, 1'b1, 1'b1, 32'h00000000},  // tie to even
         '{32'h00000001, 32'h3FC00000, 1'b1, 1'b1, 32'h00000002},
         '{32'h00800000, 32'h3F000000, 1'b1, 1'b1, 32'h00400000},  // subnormal kept
         '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1, 32'h7FC00000},
         '{32'h80000000, 32'h3F800000, 1'b1, 1'b1, 32'h00000000},
         '{32'h3F800000, 32'h40000000, 1'b0, 1'b0, 32'h0},
         '{32'h40400000, 32'h40400000, 1'b0, 1'b0, 32'h0},
         '{32'hBF800000, 32'h3F800000, 1'b1, 1'b0, 32'h0},
         // +inf and -inf land in different accumulators
         '{32'h7F800000, 32'h3F800000, 1'b0, 1'b0, 32'h0},
         '{32'hFF800000, 32'h3F800000, 1'b1, 1'b1, 32'h7FC00000},
         '{32'h4B800000, 32'h3F800000, 1'b0, 1'b0, 32'h0},
         '{32'hCB800000, 32'h3F800000, 1'b0, 1'b0, 32'h0},
         '{32'h3F800000, 32'h3F800000, 1'b1, 1'b0, 32'h0},
         '{32'h807FFFFF, 32'h7F7FFFFF, 1'b1, 1'b0, 32'h0}
      };
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         send_pair(rows[i].a, rows[i].b, rows[i].last, rows[i].known, rows[i].want);
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 84; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 84; end
            default: begin send_idle_pct = 13; stall_pct = 13; end
         endcase
         remaining = RANDOM_ITEMS / 4;
         while (remaining > 0) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
               send_pair(pick_operand(), pick_operand(), k == len - 1, 1'b0, 32'h0);
            end
            remaining -= len;
         end
      end
      req_valid <= 1'b0;
      while (expected_dot_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/fdp_pkg.sv
src/fdp_mul.sv
src/fdp_acc.sv
src/float32_dot_product_unit.sv
src/fdp_checker.sv
tb/float32_dot_product_unit_tb.sv
